// ===== src/ssfg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssfg_pkg
// Shared types and constants of the seven-segment frame generator.
// ----------------------------------------------------------------------------
package ssfg_pkg;

    localparam int SLOT_COUNT = 8;
    localparam int SLOT_INDEX_WIDTH = 3;

    localparam int CFG_INDEX_WIDTH = 1;
    localparam int CFG_DATA_WIDTH = 4;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BRIGHTNESS = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DIGITS_SCANNED = 1'b1;

    localparam logic [2:0] KIND_INIT = 3'd0;
    localparam logic [2:0] KIND_NUMBER = 3'd1;
    localparam logic [2:0] KIND_TIME = 3'd2;
    localparam logic [2:0] KIND_DATE = 3'd3;
    localparam logic [2:0] KIND_TEMP = 3'd4;

    localparam logic [3:0] ADDR_DECODE = 4'd9;
    localparam logic [3:0] ADDR_INTENSITY = 4'd10;
    localparam logic [3:0] ADDR_SCAN = 4'd11;
    localparam logic [3:0] ADDR_SHUTDOWN = 4'd12;

    localparam logic [7:0] GLYPH_DASH = 8'h01;
    localparam logic [7:0] GLYPH_DEGREE = 8'h63;
    localparam logic [7:0] GLYPH_C = 8'h4E;

    typedef struct packed {
        logic [3:0] addr;
        logic [7:0] data;
    } frame_t;

    typedef struct packed {
        frame_t [SLOT_COUNT-1:0]      slots;
        logic [SLOT_INDEX_WIDTH-1:0] first;
        logic [SLOT_INDEX_WIDTH-1:0] last;
    } job_t;

endpackage
`default_nettype wire

// ===== src/seven_segment_frame_generator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// seven_segment_frame_generator_unit
// Turns display commands into runs of driver frame words.
// ----------------------------------------------------------------------------
// flow: an accepted command is registered; number and date commands run a
//   32-bit double dabble, 4 bits per cycle, before the job is queued
// throughput: one frame word per cycle at the output while out_stall is low;
//   the front holds a command until its job is queued
// reset: queue and handshake state cleared, brightness 8, digits_scanned 7
// ----------------------------------------------------------------------------
module seven_segment_frame_generator_unit #(
    parameter int DIGIT_COUNT = 8
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     cfg_write,
    input  wire logic [ssfg_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  wire logic [ssfg_pkg::CFG_DATA_WIDTH-1:0]      cfg_data,
    input  wire logic                                     in_valid,
    output logic                                          in_stall,
    input  wire logic [2:0]                               kind,
    input  wire logic [31:0]                              number_value,
    input  wire logic [4:0]                               hour_value,
    input  wire logic [5:0]                               minute_value,
    input  wire logic [5:0]                               second_value,
    input  wire logic [4:0]                               day_value,
    input  wire logic [3:0]                               month_value,
    input  wire logic [13:0]                              year_value,
    input  wire logic [6:0]                               temperature_value,
    output logic                                          out_valid,
    input  wire logic                                     out_stall,
    output logic [3:0]                                    frame_address,
    output logic [7:0]                                    frame_data,
    output logic                                          last_frame
);
    import ssfg_pkg::*;

    logic [3:0] brightness_reg, brightness_next;
    logic [2:0] digits_scanned_reg, digits_scanned_next;

    logic       q_push;
    job_t       q_job;
    logic       q_full;
    logic       head_valid;
    job_t       head_job;
    logic       pop;

    always_comb
    begin
        brightness_next = brightness_reg;
        digits_scanned_next = digits_scanned_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BRIGHTNESS:     brightness_next = cfg_data;
                REG_DIGITS_SCANNED: digits_scanned_next = cfg_data[2:0];
                default:            brightness_next = brightness_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= 4'd8;
            digits_scanned_reg <= 3'd7;
        end
        else
        begin
            brightness_reg <= brightness_next;
            digits_scanned_reg <= digits_scanned_next;
        end
    end

    ssfg_front #(
        .DIGIT_COUNT(DIGIT_COUNT)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .number_value(number_value),
        .hour_value(hour_value),
        .minute_value(minute_value),
        .second_value(second_value),
        .day_value(day_value),
        .month_value(month_value),
        .year_value(year_value),
        .temperature_value(temperature_value),
        .brightness(brightness_reg),
        .digits_scanned(digits_scanned_reg),
        .q_push(q_push),
        .q_job(q_job),
        .q_full(q_full)
    );

    ssfg_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(q_push),
        .push_job(q_job),
        .full(q_full),
        .head_valid(head_valid),
        .head_job(head_job),
        .pop(pop)
    );

    ssfg_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .head_valid(head_valid),
        .head_job(head_job),
        .pop(pop),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .frame_address(frame_address),
        .frame_data(frame_data),
        .last_frame(last_frame)
    );

endmodule
`default_nettype wire

// ===== src/ssfg_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssfg_front
// Accepts display commands, converts numbers and years to decimal and builds
// a job of up to eight frames for the queue.
// ----------------------------------------------------------------------------
module ssfg_front #(
    parameter int DIGIT_COUNT = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [2:0]                     kind,
    input  wire logic [31:0]                    number_value,
    input  wire logic [4:0]                     hour_value,
    input  wire logic [5:0]                     minute_value,
    input  wire logic [5:0]                     second_value,
    input  wire logic [4:0]                     day_value,
    input  wire logic [3:0]                     month_value,
    input  wire logic [13:0]                    year_value,
    input  wire logic [6:0]                     temperature_value,
    input  wire logic [3:0]                     brightness,
    input  wire logic [2:0]                     digits_scanned,
    output logic                                q_push,
    output ssfg_pkg::job_t                      q_job,
    input  wire logic                           q_full
);
    import ssfg_pkg::*;

    localparam logic [SLOT_INDEX_WIDTH-1:0] ASC_LAST = SLOT_INDEX_WIDTH'(DIGIT_COUNT - 1);
    localparam logic [SLOT_INDEX_WIDTH-1:0] DESC_FIRST =
        SLOT_INDEX_WIDTH'(SLOT_COUNT - DIGIT_COUNT);
    localparam logic [SLOT_INDEX_WIDTH-1:0] SLOT_MAX = SLOT_INDEX_WIDTH'(SLOT_COUNT - 1);

    function automatic logic [7:0] seg_of(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'h7E;
            4'd1:    s = 8'h30;
            4'd2:    s = 8'h6D;
            4'd3:    s = 8'h79;
            4'd4:    s = 8'h33;
            4'd5:    s = 8'h5B;
            4'd6:    s = 8'h5F;
            4'd7:    s = 8'h70;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h7B;
            default: s = 8'h7E;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] tens_of(input logic [6:0] v);
        logic [14:0] p;
        p = 15'(v) * 15'd205;
        return p[14:11];
    endfunction

    function automatic logic [3:0] units_of(input logic [6:0] v);
        logic [6:0] r;
        r = v - {3'b000, tens_of(v)} * 7'd10;
        return r[3:0];
    endfunction

    // one double dabble step on eight bcd digits
    function automatic logic [31:0] dd_shift(input logic [31:0] bcd, input logic bit_in);
        logic [31:0] adj;
        adj = bcd;
        for (int i = 0; i < 8; i++) begin
            if (adj[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
            end
        end
        return {adj[30:0], bit_in};
    endfunction

    function automatic logic [31:0] dd_nibble(input logic [31:0] bcd, input logic [3:0] nib);
        logic [31:0] b;
        b = bcd;
        for (int k = 3; k >= 0; k--) begin
            b = dd_shift(b, nib[k]);
        end
        return b;
    endfunction

    logic        hold_reg, hold_next;
    logic        conv_reg, conv_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [2:0]  kind_reg;
    logic [31:0] src_reg, src_next;
    logic [31:0] bcd_reg, bcd_next;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;
    logic [5:0]  second_reg;
    logic [4:0]  day_reg;
    logic [3:0]  month_reg;
    logic [6:0]  temp_reg;

    logic        accept;
    logic        needs_conv;
    logic        known;
    logic        done;
    logic [6:0]  temp_sat;
    logic [7:0]  pat [SLOT_COUNT];
    logic        descending;
    job_t        job;

    assign accept = in_valid && !in_stall;
    assign needs_conv = (kind == KIND_NUMBER) || (kind == KIND_DATE);
    assign known = (kind_reg == KIND_INIT) || (kind_reg == KIND_NUMBER)
                || (kind_reg == KIND_TIME) || (kind_reg == KIND_DATE)
                || (kind_reg == KIND_TEMP);
    assign done = hold_reg && !conv_reg && (!known || !q_full);
    assign in_stall = hold_reg && !done;
    assign q_push = done && known;
    assign q_job = job;
    assign temp_sat = (temp_reg > 7'd99) ? 7'd99 : temp_reg;

    always_comb
    begin
        hold_next = hold_reg;
        conv_next = conv_reg;
        cnt_next = cnt_reg;
        src_next = src_reg;
        bcd_next = bcd_reg;
        if (accept)
        begin
            hold_next = 1'b1;
            conv_next = needs_conv;
            cnt_next = 3'd0;
            src_next = (kind == KIND_NUMBER) ? number_value : {18'b0, year_value};
            bcd_next = 32'd0;
        end
        else
        begin
            if (done)
            begin
                hold_next = 1'b0;
            end
            if (conv_reg)
            begin
                cnt_next = cnt_reg + 3'd1;
                src_next = {src_reg[27:0], 4'b0000};
                bcd_next = dd_nibble(bcd_reg, src_reg[31:28]);
                if (cnt_reg == 3'd7)
                begin
                    conv_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= 1'b0;
            conv_reg <= 1'b0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            hold_reg <= hold_next;
            conv_reg <= conv_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg <= src_next;
        bcd_reg <= bcd_next;
        if (accept)
        begin
            kind_reg <= kind;
            hour_reg <= hour_value;
            minute_reg <= minute_value;
            second_reg <= second_value;
            day_reg <= day_value;
            month_reg <= month_value;
            temp_reg <= temperature_value;
        end
    end

    // segment patterns in emission order
    always_comb
    begin
        descending = 1'b0;
        for (int k = 0; k < SLOT_COUNT; k++) begin
            pat[k] = 8'h00;
        end
        unique case (kind_reg)
            KIND_NUMBER:
            begin
                for (int k = 0; k < SLOT_COUNT; k++) begin
                    pat[k] = seg_of(bcd_reg[4*k +: 4]);
                end
            end
            KIND_TIME:
            begin
                pat[0] = seg_of(units_of({1'b0, second_reg}));
                pat[1] = seg_of(tens_of({1'b0, second_reg}));
                pat[2] = GLYPH_DASH;
                pat[3] = seg_of(units_of({1'b0, minute_reg}));
                pat[4] = seg_of(tens_of({1'b0, minute_reg}));
                pat[5] = GLYPH_DASH;
                pat[6] = seg_of(units_of({2'b00, hour_reg}));
                pat[7] = seg_of(tens_of({2'b00, hour_reg}));
            end
            KIND_DATE:
            begin
                descending = 1'b1;
                pat[0] = seg_of(tens_of({2'b00, day_reg}));
                pat[1] = seg_of(units_of({2'b00, day_reg}));
                pat[2] = seg_of(tens_of({3'b000, month_reg}));
                pat[3] = seg_of(units_of({3'b000, month_reg}));
                pat[4] = seg_of(bcd_reg[15:12]);
                pat[5] = seg_of(bcd_reg[11:8]);
                pat[6] = seg_of(bcd_reg[7:4]);
                pat[7] = seg_of(bcd_reg[3:0]);
            end
            KIND_TEMP:
            begin
                descending = 1'b1;
                pat[0] = GLYPH_DASH;
                pat[1] = GLYPH_DASH;
                pat[2] = seg_of(tens_of(temp_sat));
                pat[3] = seg_of(units_of(temp_sat));
                pat[4] = GLYPH_DEGREE;
                pat[5] = GLYPH_C;
                pat[6] = GLYPH_DASH;
                pat[7] = GLYPH_DASH;
            end
            default:
            begin
                descending = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        for (int k = 0; k < SLOT_COUNT; k++) begin
            job.slots[k].addr = descending ? 4'(SLOT_COUNT - k) : 4'(k + 1);
            job.slots[k].data = pat[k];
        end
        job.first = descending ? DESC_FIRST : '0;
        job.last = descending ? SLOT_MAX : ASC_LAST;
        if (kind_reg == KIND_INIT)
        begin
            job.slots[0] = '{addr: ADDR_DECODE, data: 8'h00};
            job.slots[1] = '{addr: ADDR_SCAN, data: {5'b00000, digits_scanned}};
            job.slots[2] = '{addr: ADDR_INTENSITY, data: {4'b0000, brightness}};
            job.slots[3] = '{addr: ADDR_SHUTDOWN, data: 8'h01};
            job.first = '0;
            job.last = SLOT_INDEX_WIDTH'(3);
        end
    end

endmodule
`default_nettype wire

// ===== src/ssfg_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssfg_queue
// Two-entry job queue between the command front and the frame back end.
// ----------------------------------------------------------------------------
module ssfg_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  ssfg_pkg::job_t      push_job,
    output logic                full,
    output logic                head_valid,
    output ssfg_pkg::job_t      head_job,
    input  wire logic           pop
);
    import ssfg_pkg::*;

    job_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

// ===== src/ssfg_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssfg_back
// Walks the head job slot by slot and sends one frame word per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module ssfg_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           head_valid,
    input  ssfg_pkg::job_t      head_job,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [3:0]          frame_address,
    output logic [7:0]          frame_data,
    output logic                last_frame
);
    import ssfg_pkg::*;

    logic [SLOT_INDEX_WIDTH-1:0] idx_reg, idx_next;
    logic                        started_reg, started_next;
    logic                        valid_reg, valid_next;
    logic [3:0]                  addr_reg;
    logic [7:0]                  data_reg;
    logic                        last_reg;

    logic [SLOT_INDEX_WIDTH-1:0] cur;
    logic                        out_free;
    logic                        emit;
    logic                        at_last;
    frame_t                      cur_frame;

    assign cur = started_reg ? idx_reg : head_job.first;
    assign cur_frame = head_job.slots[cur];
    assign at_last = (cur == head_job.last);
    assign out_free = !valid_reg || !out_stall;
    assign emit = head_valid && out_free;
    assign pop = emit && at_last;

    assign out_valid = valid_reg;
    assign frame_address = addr_reg;
    assign frame_data = data_reg;
    assign last_frame = last_reg;

    always_comb
    begin
        idx_next = idx_reg;
        started_next = started_reg;
        valid_next = out_free ? 1'b0 : valid_reg;
        if (emit)
        begin
            valid_next = 1'b1;
            if (at_last)
            begin
                started_next = 1'b0;
            end
            else
            begin
                started_next = 1'b1;
                idx_next = cur + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            started_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            started_reg <= started_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            addr_reg <= cur_frame.addr;
            data_reg <= cur_frame.data;
            last_reg <= at_last;
        end
    end

endmodule
`default_nettype wire

// ===== src/ssfg_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssfg_checker
// Port-level checks on the frame word stream of the frame generator.
// ----------------------------------------------------------------------------
module ssfg_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [3:0]  frame_address,
    input  wire logic [7:0]  frame_data,
    input  wire logic        last_frame
);

    // stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frame_address)
            && $stable(frame_data) && $stable(last_frame))
        else $error("stalled output word changed");

    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> frame_address >= 4'd1 && frame_address <= 4'd12)
        else $error("frame address out of range");

    // shutdown exit closes the init run
    a_shutdown_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_address == 4'd12 |-> frame_data == 8'h01 && last_frame)
        else $error("shutdown word malformed");

    // decode-off opens the init run, followed by the scan limit
    a_decode_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && frame_address == 4'd9
            |-> frame_data == 8'h00 && !last_frame)
        else $error("decode word malformed");

endmodule

bind seven_segment_frame_generator_unit ssfg_checker u_ssfg_checker (.*);
`default_nettype wire

// ===== bench/seven_segment_frame_generator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// seven_segment_frame_generator_unit_tb
// Drives display commands into the frame generator and checks every frame
// word that comes out against a local prediction of the command's run. The
// run covers directed edge commands, then random commands under changing
// brightness and scan limit, random gaps on both sides and one long output
// hold-off that backs the generator up.
// ----------------------------------------------------------------------------
module seven_segment_frame_generator_unit_tb;

    import ssfg_pkg::*;

    localparam int DIGIT_COUNT = 8;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_LIMIT = 10;

    localparam logic [7:0] SEG_TABLE [10] = '{
        8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h7B
    };

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] number;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [6:0]  temp;
    } cmd_t;

    typedef struct packed {
        logic [3:0] addr;
        logic [7:0] data;
        logic       last_flag;
    } frame_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [2:0] kind = '0;
    logic [31:0] number_value = '0;
    logic [4:0] hour_value = '0;
    logic [5:0] minute_value = '0;
    logic [5:0] second_value = '0;
    logic [4:0] day_value = '0;
    logic [3:0] month_value = '0;
    logic [13:0] year_value = '0;
    logic [6:0] temperature_value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [3:0] frame_address;
    logic [7:0] frame_data;
    logic last_frame;

    cmd_t pending_cmds [$];
    cmd_t driven_cmd;
    frame_word_t frames_expected [$];
    frame_word_t command_run [$];

    logic [3:0] model_brightness = 4'd8;
    logic [2:0] model_scan_limit = 3'd7;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic hold_armed = 1'b0;
    logic hold_done;
    int hold_left;
    int error_count = 0;
    int cycle_count = 0;

    seven_segment_frame_generator_unit #(
        .DIGIT_COUNT(DIGIT_COUNT)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .number_value(number_value),
        .hour_value(hour_value),
        .minute_value(minute_value),
        .second_value(second_value),
        .day_value(day_value),
        .month_value(month_value),
        .year_value(year_value),
        .temperature_value(temperature_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .frame_address(frame_address),
        .frame_data(frame_data),
        .last_frame(last_frame)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] seg_pattern(int unsigned digit);
        return SEG_TABLE[digit % 10];
    endfunction

    function automatic void add_frame(logic [3:0] addr, logic [7:0] data);
        frame_word_t f;
        f.addr = addr;
        f.data = data;
        f.last_flag = 1'b0;
        command_run.push_back(f);
    endfunction

    function automatic void add_digit(int unsigned pos, logic [7:0] data);
        if (pos < DIGIT_COUNT && pos < 8)
            add_frame(4'(pos + 1), data);
    endfunction

    function automatic void encode_command(cmd_t c);
        int unsigned v;
        int unsigned h;
        int unsigned m;
        int unsigned s;
        int unsigned t;
        command_run.delete();
        case (c.kind)
            KIND_INIT:
            begin
                add_frame(ADDR_DECODE, 8'h00);
                add_frame(ADDR_SCAN, {5'd0, model_scan_limit});
                add_frame(ADDR_INTENSITY, {4'd0, model_brightness});
                add_frame(ADDR_SHUTDOWN, 8'h01);
            end
            KIND_NUMBER:
            begin
                v = c.number;
                for (int i = 0; i < 8; i++)
                begin
                    add_digit(i, seg_pattern(v % 10));
                    v = v / 10;
                end
            end
            KIND_TIME:
            begin
                h = c.hour;
                m = c.minute;
                s = c.second;
                add_digit(0, seg_pattern(s % 10));
                add_digit(1, seg_pattern(s / 10));
                add_digit(2, GLYPH_DASH);
                add_digit(3, seg_pattern(m % 10));
                add_digit(4, seg_pattern(m / 10));
                add_digit(5, GLYPH_DASH);
                add_digit(6, seg_pattern(h % 10));
                add_digit(7, seg_pattern(h / 10));
            end
            KIND_DATE:
            begin
                add_digit(7, seg_pattern(c.day / 10));
                add_digit(6, seg_pattern(c.day % 10));
                add_digit(5, seg_pattern(c.month / 10));
                add_digit(4, seg_pattern(c.month % 10));
                add_digit(3, seg_pattern(c.year / 1000));
                add_digit(2, seg_pattern(c.year / 100));
                add_digit(1, seg_pattern(c.year / 10));
                add_digit(0, seg_pattern(c.year));
            end
            KIND_TEMP:
            begin
                t = (c.temp > 7'd99) ? 99 : c.temp;
                add_digit(7, GLYPH_DASH);
                add_digit(6, GLYPH_DASH);
                add_digit(5, seg_pattern(t / 10));
                add_digit(4, seg_pattern(t % 10));
                add_digit(3, GLYPH_DEGREE);
                add_digit(2, GLYPH_C);
                add_digit(1, GLYPH_DASH);
                add_digit(0, GLYPH_DASH);
            end
            default:
            begin
            end
        endcase
        if (command_run.size() != 0)
            command_run[command_run.size() - 1].last_flag = 1'b1;
        foreach (command_run[i])
            frames_expected.push_back(command_run[i]);
    endfunction

    function automatic void queue_command(logic [2:0] k, logic [31:0] num, logic [4:0] h,
                                          logic [5:0] m, logic [5:0] s, logic [4:0] d,
                                          logic [3:0] mo, logic [13:0] y, logic [6:0] t);
        cmd_t c;
        c.kind = k;
        c.number = num;
        c.hour = h;
        c.minute = m;
        c.second = s;
        c.day = d;
        c.month = mo;
        c.year = y;
        c.temp = t;
        pending_cmds.push_back(c);
    endfunction

    function automatic cmd_t random_command();
        cmd_t c;
        if ($urandom_range(9) == 0)
            c.kind = 3'($urandom_range(7, 5));
        else
            c.kind = 3'($urandom_range(4));
        case ($urandom_range(3))
            0: c.number = $urandom;
            1: c.number = $urandom_range(999);
            2: c.number = $urandom_range(99999999);
            default: c.number = $urandom_range(32'hFFFF_FFFF, 100000000);
        endcase
        if ($urandom_range(4) == 0)
        begin
            c.hour = 5'($urandom);
            c.minute = 6'($urandom);
            c.second = 6'($urandom);
            c.day = 5'($urandom);
            c.month = 4'($urandom);
            c.year = 14'($urandom);
            c.temp = 7'($urandom);
        end
        else
        begin
            c.hour = 5'($urandom_range(23));
            c.minute = 6'($urandom_range(59));
            c.second = 6'($urandom_range(59));
            c.day = 5'($urandom_range(31, 1));
            c.month = 4'($urandom_range(12, 1));
            c.year = 14'($urandom_range(9999));
            c.temp = 7'($urandom_range(99));
        end
        return c;
    endfunction

    task automatic report_mismatch(string what, int expected_val, int actual_val);
        if (error_count < REPORT_LIMIT)
            $display("mismatch on %s: expected %0h, got %0h", what, expected_val, actual_val);
        error_count++;
    endtask

    // command word driver
    always @(posedge clk or negedge rst_n)
    begin
        cmd_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                encode_command(driven_cmd);
            if (!in_valid || !in_stall)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_cmds.pop_front();
                    driven_cmd <= nxt;
                    in_valid <= 1'b1;
                    kind <= nxt.kind;
                    number_value <= nxt.number;
                    hour_value <= nxt.hour;
                    minute_value <= nxt.minute;
                    second_value <= nxt.second;
                    day_value <= nxt.day;
                    month_value <= nxt.month;
                    year_value <= nxt.year;
                    temperature_value <= nxt.temp;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output stall, with one long hold-off once armed
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_armed && !hold_done)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // frame word monitor
    always @(posedge clk)
    begin
        frame_word_t exp_word;
        if (rst_n && out_valid && !out_stall)
        begin
            if (frames_expected.size() == 0)
            begin
                report_mismatch("unexpected frame", 0, {frame_address, frame_data});
            end
            else
            begin
                exp_word = frames_expected.pop_front();
                if (frame_address !== exp_word.addr)
                    report_mismatch("frame_address", exp_word.addr, frame_address);
                if (frame_data !== exp_word.data)
                    report_mismatch("frame_data", exp_word.data, frame_data);
                if (last_frame !== exp_word.last_flag)
                    report_mismatch("last_frame", exp_word.last_flag, last_frame);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_register(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_BRIGHTNESS)
            model_brightness = val;
        else
            model_scan_limit = val[2:0];
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || in_valid || frames_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(int count);
        @(negedge clk);
        pending_cmds.push_back(random_command());
        queue_command(KIND_INIT, '0, '0, '0, '0, '0, '0, '0, '0);
        for (int i = 2; i < count; i++)
            pending_cmds.push_back(random_command());
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct <= 26;
        recv_idle_pct <= 83;
        @(negedge clk);
        queue_command(KIND_INIT, '0, '0, '0, '0, '0, '0, '0, '0);
        queue_command(KIND_NUMBER, 32'd0, '0, '0, '0, '0, '0, '0, '0);
        queue_command(KIND_NUMBER, 32'hFFFF_FFFF, '1, '1, '1, '1, '1, '1, '1);
        queue_command(KIND_NUMBER, 32'd12345678, '0, '0, '0, '0, '0, '0, '0);
        queue_command(KIND_NUMBER, 32'd99999999, '0, '0, '0, '0, '0, '0, '0);
        queue_command(KIND_TIME, '0, 5'd23, 6'd59, 6'd59, '0, '0, '0, '0);
        queue_command(KIND_TIME, '0, 5'd0, 6'd0, 6'd0, '0, '0, '0, '0);
        queue_command(KIND_TIME, '0, 5'd31, 6'd63, 6'd63, '0, '0, '0, '0);
        queue_command(KIND_DATE, '0, '0, '0, '0, 5'd31, 4'd12, 14'd9999, '0);
        queue_command(KIND_DATE, '0, '0, '0, '0, 5'd1, 4'd1, 14'd0, '0);
        queue_command(KIND_DATE, '0, '0, '0, '0, 5'd0, 4'd15, 14'd16383, '0);
        queue_command(KIND_TEMP, '0, '0, '0, '0, '0, '0, '0, 7'd0);
        queue_command(KIND_TEMP, '0, '0, '0, '0, '0, '0, '0, 7'd45);
        queue_command(KIND_TEMP, '0, '0, '0, '0, '0, '0, '0, 7'd99);
        queue_command(KIND_TEMP, '0, '0, '0, '0, '0, '0, '0, 7'd100);
        queue_command(KIND_TEMP, '0, '0, '0, '0, '0, '0, '0, 7'd127);
        queue_command(3'd5, 32'hFFFF_FFFF, '1, '1, '1, '1, '1, '1, '1);
        queue_command(3'd6, '0, '0, '0, '0, '0, '0, '0, '0);
        queue_command(3'd7, '0, '0, '0, '0, '0, '0, '0, '0);
        queue_command(KIND_INIT, '1, '1, '1, '1, '1, '1, '1, '1);
        wait_drained();

        write_register(REG_BRIGHTNESS, 4'd0);
        write_register(REG_DIGITS_SCANNED, 4'd0);
        run_random(130);
        wait_drained();

        send_idle_pct <= 83;
        recv_idle_pct <= 26;
        write_register(REG_BRIGHTNESS, 4'd15);
        write_register(REG_DIGITS_SCANNED, 4'd7);
        run_random(130);
        wait_drained();

        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        write_register(REG_BRIGHTNESS, 4'($urandom_range(14, 1)));
        write_register(REG_DIGITS_SCANNED, 4'($urandom_range(6, 1)));
        run_random(140);
        hold_armed <= 1'b1;
        wait_drained();

        if (error_count == 0 && frames_expected.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/ssfg_pkg.sv
src/ssfg_front.sv
src/ssfg_queue.sv
src/ssfg_back.sv
src/seven_segment_frame_generator_unit.sv
src/ssfg_checker.sv
bench/seven_segment_frame_generator_unit_tb.sv
